// File: design/cmdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdf_pkg - shared types and constants of the chunked message deframer
// phase and status codes, result record and framing constants
// ----------------------------------------------------------------------------
package cmdf_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;

    localparam logic [7:0] CSUM_BASE   = 8'hAA;
    localparam logic [7:0] CSUM_BYPASS = 8'h88;
    localparam logic [7:0] MARKER_MASK = 8'hFE;

    localparam int PLEN_W = 12;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_CSUM_BAD   = 3'd1,
        ST_SHORT      = 3'd2,
        ST_BAD_CONT   = 3'd3,
        ST_OVERFLOW   = 3'd4,
        ST_SIZE_ZERO  = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              last;
        status_t           status;
        logic [3:0]        category;
        logic [2:0]        command;
        logic [PLEN_W-1:0] payload_length;
        logic              handshake_marker;
    } out_item_t;

endpackage

// File: design/cmdf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdf_if - byte and result channels of the chunked message deframer
// valid/ready channels with source and sink modports
// ----------------------------------------------------------------------------
interface cmdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_start;
    logic       chunk_end;

    modport source (output valid, output data_byte, output chunk_start,
                    output chunk_end, input ready);
    modport sink   (input valid, input data_byte, input chunk_start,
                    input chunk_end, output ready);
endinterface

interface cmdf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last;
    logic [2:0]  status;
    logic [3:0]  category;
    logic [2:0]  command;
    logic [11:0] payload_length;
    logic        handshake_marker;

    modport source (output valid, output out_byte, output last, output status,
                    output category, output command, output payload_length,
                    output handshake_marker, input ready);
    modport sink   (input valid, input out_byte, input last, input status,
                    input category, input command, input payload_length,
                    input handshake_marker, output ready);
endinterface

// File: design/cmdf_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdf_parse - message framing state and per-byte decision logic
// tracks header, size, byte count and checksum; forms at most one result per byte
// ----------------------------------------------------------------------------
module cmdf_parse #(
    parameter int BUFFER_BYTES = cmdf_pkg::BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    input  logic                chunk_start,
    input  logic                chunk_end,
    output logic                res_valid,
    output cmdf_pkg::out_item_t res
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int LEN_W = (CNT_W > cmdf_pkg::PLEN_W) ? CNT_W : cmdf_pkg::PLEN_W;

    cmdf_pkg::phase_t   phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   exp_reg, exp_next;
    logic [7:0]         header_reg, header_next;
    logic [7:0]         size_low_reg, size_low_next;
    logic [7:0]         sum_reg, sum_next;
    logic [1:0]         fcb_reg, fcb_next;

    logic [16:0]        exp_full;
    logic [15:0]        size_full;
    logic [CNT_W:0]     cnt_inc;
    logic [LEN_W-1:0]   plen_full;
    logic [7:0]         sum_add;
    logic [7:0]         csum_want;
    logic               hs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= cmdf_pkg::PH_IDLE;
            cnt_reg      <= '0;
            exp_reg      <= '0;
            header_reg   <= '0;
            size_low_reg <= '0;
            sum_reg      <= '0;
            fcb_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            exp_reg      <= exp_next;
            header_reg   <= header_next;
            size_low_reg <= size_low_next;
            sum_reg      <= sum_next;
            fcb_reg      <= fcb_next;
        end
    end

    assign size_full = {data_byte, size_low_reg};
    assign exp_full  = {1'b0, size_full} + 17'd3;
    assign cnt_inc   = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign plen_full = LEN_W'(exp_reg) - LEN_W'(4);
    assign sum_add   = sum_reg + data_byte;
    assign csum_want = cmdf_pkg::CSUM_BASE - sum_reg;
    assign hs        = (data_byte == cmdf_pkg::CSUM_BYPASS);

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        exp_next      = exp_reg;
        header_next   = header_reg;
        size_low_next = size_low_reg;
        sum_next      = sum_reg;
        fcb_next      = fcb_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.category  = header_reg[7:4];
        res.command   = header_reg[3:1];

        if (in_fire)
        begin
            case (phase_reg)
                cmdf_pkg::PH_HEAD:
                begin
                    if (chunk_start)
                    begin
                        // header cut short by a new chunk, which opens a new header
                        res_valid     = 1'b1;
                        res.last      = 1'b1;
                        res.status    = cmdf_pkg::ST_SHORT;
                        header_next   = data_byte;
                        sum_next      = data_byte;
                        size_low_next = '0;
                        exp_next      = '0;
                        cnt_next      = CNT_W'(1);
                        fcb_next      = 2'd1;
                        phase_next    = chunk_end ? cmdf_pkg::PH_IDLE : cmdf_pkg::PH_HEAD;
                    end
                    else if (fcb_reg == 2'd1)
                    begin
                        size_low_next = data_byte;
                        sum_next      = sum_add;
                        fcb_next      = 2'd2;
                        cnt_next      = CNT_W'(2);
                        if (chunk_end)
                        begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            res.status = cmdf_pkg::ST_SHORT;
                            phase_next = cmdf_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        fcb_next   = 2'd3;
                        cnt_next   = CNT_W'(3);
                        exp_next   = exp_full[CNT_W-1:0];
                        phase_next = cmdf_pkg::PH_BODY;
                        if (size_full == 16'd0)
                        begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            res.status = cmdf_pkg::ST_SIZE_ZERO;
                            phase_next = cmdf_pkg::PH_IDLE;
                        end
                        else if (exp_full > 17'(BUFFER_BYTES))
                        begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            res.status = cmdf_pkg::ST_OVERFLOW;
                            phase_next = cmdf_pkg::PH_IDLE;
                        end
                    end
                end

                cmdf_pkg::PH_BODY:
                begin
                    if (chunk_start)
                    begin
                        // continuation marker must be the command byte with bit 0 set
                        if (!data_byte[0] ||
                            ((data_byte & cmdf_pkg::MARKER_MASK) != header_reg))
                        begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            res.status = cmdf_pkg::ST_BAD_CONT;
                            phase_next = cmdf_pkg::PH_IDLE;
                        end
                    end
                    else if (cnt_inc < {1'b0, exp_reg})
                    begin
                        sum_next     = sum_add;
                        cnt_next     = cnt_inc[CNT_W-1:0];
                        res_valid    = 1'b1;
                        res          = '0;
                        res.out_byte = data_byte;
                    end
                    else
                    begin
                        // checksum byte
                        cnt_next             = cnt_inc[CNT_W-1:0];
                        res_valid            = 1'b1;
                        res.last             = 1'b1;
                        res.handshake_marker = hs;
                        res.status           = (hs || (csum_want == data_byte)) ?
                                               cmdf_pkg::ST_OK : cmdf_pkg::ST_CSUM_BAD;
                        res.payload_length   = plen_full[cmdf_pkg::PLEN_W-1:0];
                        phase_next           = cmdf_pkg::PH_IDLE;
                    end
                end

                default:
                begin
                    phase_next = cmdf_pkg::PH_IDLE;
                    if (chunk_start)
                    begin
                        header_next   = data_byte;
                        sum_next      = data_byte;
                        size_low_next = '0;
                        exp_next      = '0;
                        cnt_next      = CNT_W'(1);
                        fcb_next      = 2'd1;
                        phase_next    = cmdf_pkg::PH_HEAD;
                        if (chunk_end)
                        begin
                            res_valid    = 1'b1;
                            res.last     = 1'b1;
                            res.status   = cmdf_pkg::ST_SHORT;
                            res.category = data_byte[7:4];
                            res.command  = data_byte[3:1];
                            phase_next   = cmdf_pkg::PH_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    // body count stays below the expected message length, which stays within the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == cmdf_pkg::PH_BODY |-> (cnt_reg < exp_reg) &&
                                           (CNT_W'(BUFFER_BYTES) >= exp_reg))
    else $error("byte count out of range in body");

    // header holds one or two bytes while waiting for the size
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == cmdf_pkg::PH_HEAD |-> (fcb_reg == 2'd1) || (fcb_reg == 2'd2))
    else $error("header byte count out of range");

    // any status result ends the message
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |=> (phase_reg == cmdf_pkg::PH_IDLE) ||
                                  (phase_reg == cmdf_pkg::PH_HEAD))
    else $error("message still open after status");

endmodule

// File: design/cmdf_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdf_outbuf - result register with skid stage
// holds results while the sink stalls and keeps the byte side running until the skid stage fills
// ----------------------------------------------------------------------------
module cmdf_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cmdf_pkg::out_item_t push_item,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output cmdf_pkg::out_item_t out_item
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    cmdf_pkg::out_item_t out_item_reg, out_item_next;
    cmdf_pkg::out_item_t skid_item_reg, skid_item_next;
    logic                pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;

        if (pop)
        begin
            out_valid_next  = skid_valid_reg;
            out_item_next   = skid_item_reg;
            skid_valid_next = 1'b0;
        end

        if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_item_next  = push_item;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_item_next  = push_item;
            end
        end
    end

    // skid stage only fills behind a full result register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
    else $error("skid stage full with empty result register");

    // no push lands on a full skid stage
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
    else $error("result pushed into full buffer");

endmodule

// File: design/chunked_message_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_message_deframer_core - deframer for chunked command messages
//
//   channel  dir  transaction
//   chunk    in   one received byte with chunk start and end marks
//   msg      out  one payload byte or one end-of-message status record
//
// takes one byte per cycle while chunk.ready is high; the result of a byte is formed
// from the framing state and goes to the result register, or to the skid stage while the sink stalls
// reset clears the framing state and both result stages
// chunk.ready drops only while result register and skid stage are both full
// ----------------------------------------------------------------------------
module chunked_message_deframer_core #(
    parameter int BUFFER_BYTES = cmdf_pkg::BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cmdf_in_if.sink     chunk,
    cmdf_out_if.source  msg
);

    logic                in_fire;
    logic                space;
    logic                res_valid;
    cmdf_pkg::out_item_t res;
    cmdf_pkg::out_item_t out_item;

    assign chunk.ready = space;
    assign in_fire     = chunk.valid && space;

    cmdf_parse #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .data_byte   (chunk.data_byte),
        .chunk_start (chunk.chunk_start),
        .chunk_end   (chunk.chunk_end),
        .res_valid   (res_valid),
        .res         (res)
    );

    cmdf_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_item (res),
        .space     (space),
        .out_valid (msg.valid),
        .out_ready (msg.ready),
        .out_item  (out_item)
    );

    assign msg.out_byte         = out_item.out_byte;
    assign msg.last             = out_item.last;
    assign msg.status           = out_item.status;
    assign msg.category         = out_item.category;
    assign msg.command          = out_item.command;
    assign msg.payload_length   = out_item.payload_length;
    assign msg.handshake_marker = out_item.handshake_marker;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the chunked message deframer
// chunked byte streams go in with random bursts and gaps while the result
// side stalls on its own pattern; every result is checked field by field
// against an in-bench model of the framing, checksum and error rules
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       stop;
    } chunk_byte_t;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_TOGGLE, RX_HEAVY} rx_mode_t;

    class deframer_scoreboard;
        cmdf_pkg::phase_t    phase;
        logic [12:0]         taken;
        logic [16:0]         expect_len;
        logic [7:0]          header;
        logic [7:0]          size_lo;
        logic [7:0]          byte_sum;
        logic [1:0]          head_taken;
        cmdf_pkg::out_item_t pending[$];
        int                  fails;

        function new();
            phase      = cmdf_pkg::PH_IDLE;
            taken      = '0;
            expect_len = '0;
            header     = '0;
            size_lo    = '0;
            byte_sum   = '0;
            head_taken = '0;
            fails      = 0;
        endfunction

        function void push_payload(logic [7:0] b);
            cmdf_pkg::out_item_t r;
            r = '0;
            r.status = cmdf_pkg::ST_OK;
            r.out_byte = b;
            pending.push_back(r);
        endfunction

        function void push_status(cmdf_pkg::status_t st, logic [11:0] plen, logic hs);
            cmdf_pkg::out_item_t r;
            r = '0;
            r.last = 1'b1;
            r.status = st;
            r.category = header[7:4];
            r.command = header[3:1];
            r.payload_length = plen;
            r.handshake_marker = hs;
            pending.push_back(r);
            phase = cmdf_pkg::PH_IDLE;
        endfunction

        function void open_message(logic [7:0] b);
            header     = b;
            byte_sum   = b;
            size_lo    = '0;
            expect_len = '0;
            taken      = 13'd1;
            head_taken = 2'd1;
            phase      = cmdf_pkg::PH_HEAD;
        endfunction

        function void note_byte(chunk_byte_t t);
            logic [15:0] size;
            logic        hs;
            logic [7:0]  want;
            case (phase)
                cmdf_pkg::PH_HEAD:
                begin
                    if (t.start)
                    begin
                        push_status(cmdf_pkg::ST_SHORT, '0, 1'b0);
                        open_message(t.data);
                        if (t.stop)
                            phase = cmdf_pkg::PH_IDLE;
                    end
                    else if (head_taken == 2'd1)
                    begin
                        size_lo = t.data;
                        byte_sum = byte_sum + t.data;
                        head_taken = 2'd2;
                        taken = 13'd2;
                        if (t.stop)
                            push_status(cmdf_pkg::ST_SHORT, '0, 1'b0);
                    end
                    else
                    begin
                        byte_sum = byte_sum + t.data;
                        head_taken = 2'd3;
                        taken = 13'd3;
                        size = {t.data, size_lo};
                        expect_len = 17'(size) + 17'd3;
                        if (size == 16'd0)
                            push_status(cmdf_pkg::ST_SIZE_ZERO, '0, 1'b0);
                        else if (expect_len > 17'(cmdf_pkg::BUFFER_BYTES_DEF))
                            push_status(cmdf_pkg::ST_OVERFLOW, '0, 1'b0);
                        else
                            phase = cmdf_pkg::PH_BODY;
                    end
                end
                cmdf_pkg::PH_BODY:
                begin
                    if (t.start)
                    begin
                        if (!t.data[0] || (t.data & cmdf_pkg::MARKER_MASK) != header)
                            push_status(cmdf_pkg::ST_BAD_CONT, '0, 1'b0);
                    end
                    else if (17'(taken) + 17'd1 < expect_len)
                    begin
                        byte_sum = byte_sum + t.data;
                        taken = taken + 13'd1;
                        push_payload(t.data);
                    end
                    else
                    begin
                        taken = taken + 13'd1;
                        hs = (t.data == cmdf_pkg::CSUM_BYPASS);
                        want = cmdf_pkg::CSUM_BASE - byte_sum;
                        push_status((hs || want == t.data) ? cmdf_pkg::ST_OK
                                                           : cmdf_pkg::ST_CSUM_BAD,
                                    12'(expect_len - 17'd4), hs);
                    end
                end
                default:
                begin
                    phase = cmdf_pkg::PH_IDLE;
                    if (t.start)
                    begin
                        open_message(t.data);
                        if (t.stop)
                            push_status(cmdf_pkg::ST_SHORT, '0, 1'b0);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(cmdf_pkg::out_item_t got);
            cmdf_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: last %0b status %0d out_byte %0h",
                       got.last, got.status, got.out_byte);
                fails++;
                return;
            end
            want = pending.pop_front();
            compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            compare_field("last", 16'(want.last), 16'(got.last));
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("category", 16'(want.category), 16'(got.category));
            compare_field("command", 16'(want.command), 16'(got.command));
            compare_field("payload_length", 16'(want.payload_length),
                          16'(got.payload_length));
            compare_field("handshake_marker", 16'(want.handshake_marker),
                          16'(got.handshake_marker));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cmdf_in_if  chunk();
    cmdf_out_if msg();

    chunked_message_deframer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chunk (chunk),
        .msg   (msg)
    );

    deframer_scoreboard board;
    chunk_byte_t        chunk_bytes[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void add_chunk_byte(logic [7:0] data, logic start, logic stop);
        chunk_byte_t t;
        t.data = data;
        t.start = start;
        t.stop = stop;
        chunk_bytes.push_back(t);
    endfunction

    task automatic queue_directed();
        // padding in idle
        add_chunk_byte(8'h5A, 1'b0, 1'b0);
        // one-byte first chunk
        add_chunk_byte(8'hFF, 1'b1, 1'b1);
        // two-byte first chunk
        add_chunk_byte(8'h20, 1'b1, 1'b0);
        add_chunk_byte(8'h05, 1'b0, 1'b1);
        // new chunk before the header is complete, then size zero
        add_chunk_byte(8'h30, 1'b1, 1'b0);
        add_chunk_byte(8'h40, 1'b1, 1'b0);
        add_chunk_byte(8'h00, 1'b0, 1'b0);
        add_chunk_byte(8'h00, 1'b0, 1'b1);
        // smallest overflowing size
        add_chunk_byte(8'hE4, 1'b1, 1'b0);
        add_chunk_byte(8'hFE, 1'b0, 1'b0);
        add_chunk_byte(8'h0F, 1'b0, 1'b1);
        // two chunks, bypass checksum, padding after the message
        add_chunk_byte(8'h12, 1'b1, 1'b0);
        add_chunk_byte(8'h02, 1'b0, 1'b0);
        add_chunk_byte(8'h00, 1'b0, 1'b1);
        add_chunk_byte(8'h13, 1'b1, 1'b0);
        add_chunk_byte(8'h00, 1'b0, 1'b0);
        add_chunk_byte(cmdf_pkg::CSUM_BYPASS, 1'b0, 1'b0);
        add_chunk_byte(8'h77, 1'b0, 1'b1);
        // marker without bit 0
        add_chunk_byte(8'h44, 1'b1, 1'b0);
        add_chunk_byte(8'h01, 1'b0, 1'b0);
        add_chunk_byte(8'h00, 1'b0, 1'b1);
        add_chunk_byte(8'h44, 1'b1, 1'b1);
        // wrong checksum
        add_chunk_byte(8'h50, 1'b1, 1'b0);
        add_chunk_byte(8'h01, 1'b0, 1'b0);
        add_chunk_byte(8'h00, 1'b0, 1'b0);
        add_chunk_byte(8'h00, 1'b0, 1'b1);
    endtask

    function automatic void queue_noise();
        repeat ($urandom_range(6, 1))
            add_chunk_byte(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0,
                           $urandom_range(3, 0) == 0);
    endfunction

    function automatic void queue_message(bit full_size);
        logic [7:0]  hdr;
        logic [7:0]  mark;
        logic [7:0]  csum;
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] size;
        logic [7:0]  body[$];
        int          kind;
        int          chunk_max;
        int          pad;
        int          pos;
        int          take;
        int          tail;
        int          i;
        bit          break_marker;
        kind = $urandom_range(19, 0);
        hdr = 8'($urandom_range(255, 0));
        if (kind != 0)
            hdr[0] = 1'b0;
        if (full_size)
            size = 16'(cmdf_pkg::BUFFER_BYTES_DEF - 3);
        else if (kind == 1)
            size = '0;
        else if (kind == 2)
            size = 16'($urandom_range(65535, cmdf_pkg::BUFFER_BYTES_DEF - 2));
        else if (kind == 3)
            size = 16'($urandom_range(200, 1));
        else
            size = 16'($urandom_range(24, 1));
        body = {hdr, size[7:0], size[15:8]};
        sum = hdr + size[7:0] + size[15:8];
        if (size != 0 && size <= cmdf_pkg::BUFFER_BYTES_DEF - 3)
        begin
            for (i = 1; i < size; i++)
            begin
                b = 8'($urandom_range(255, 0));
                body.push_back(b);
                sum = sum + b;
            end
            case ($urandom_range(9, 0))
                7: csum = cmdf_pkg::CSUM_BYPASS;
                8, 9: csum = 8'($urandom_range(255, 0));
                default: csum = cmdf_pkg::CSUM_BASE - sum;
            endcase
            if (full_size)
                csum = cmdf_pkg::CSUM_BASE - sum;
            body.push_back(csum);
        end
        break_marker = !full_size && $urandom_range(9, 0) == 0;
        chunk_max = (full_size || $urandom_range(3, 0) == 0) ? 64 : $urandom_range(12, 3);
        pad = $urandom_range(3, 0);
        pos = 0;
        while (pos < body.size())
        begin
            take = (pos == 0) ? $urandom_range(chunk_max, 3) : $urandom_range(chunk_max, 1);
            if (take > body.size() - pos)
                take = body.size() - pos;
            if (pos != 0)
            begin
                mark = hdr | 8'h01;
                if (break_marker)
                begin
                    mark = ($urandom_range(1, 0) == 0) ? (hdr & cmdf_pkg::MARKER_MASK)
                         : ((hdr | 8'h01) ^ (8'h02 << $urandom_range(6, 0)));
                    break_marker = 1'b0;
                end
                add_chunk_byte(mark, 1'b1, 1'b0);
            end
            tail = (pos + take == body.size()) ? pad : 0;
            for (i = 0; i < take; i++)
                add_chunk_byte(body[pos + i], pos == 0 && i == 0, i == take - 1 && tail == 0);
            for (i = 0; i < tail; i++)
                add_chunk_byte(8'($urandom_range(255, 0)), 1'b0, i == tail - 1);
            pos += take;
        end
    endfunction

    task automatic send_bytes();
        chunk_byte_t t;
        int          burst;
        burst = $urandom_range(16, 1);
        while (chunk_bytes.size() != 0)
        begin
            if (burst == 0)
            begin
                chunk.valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(negedge clk);
                burst = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 60)
                      : $urandom_range(16, 1);
            end
            t = chunk_bytes.pop_front();
            chunk.valid <= 1'b1;
            chunk.data_byte <= t.data;
            chunk.chunk_start <= t.start;
            chunk.chunk_end <= t.stop;
            @(posedge clk);
            while (!chunk.ready)
                @(posedge clk);
            board.note_byte(t);
            burst--;
            @(negedge clk);
        end
        chunk.valid <= 1'b0;
    endtask

    initial
    begin
        rx_mode_t mode;
        msg.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = rx_mode_t'($urandom_range(3, 0));
            repeat ($urandom_range(120, 20))
            begin
                @(negedge clk);
                case (mode)
                    RX_OPEN: msg.ready <= 1'b1;
                    RX_LIGHT: msg.ready <= ($urandom_range(3, 0) != 0);
                    RX_TOGGLE: msg.ready <= ~msg.ready;
                    default: msg.ready <= ($urandom_range(7, 0) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cmdf_pkg::out_item_t got;
        if (rst_n && msg.valid && msg.ready)
        begin
            got.out_byte = msg.out_byte;
            got.last = msg.last;
            got.status = cmdf_pkg::status_t'(msg.status);
            got.category = msg.category;
            got.command = msg.command;
            got.payload_length = msg.payload_length;
            got.handshake_marker = msg.handshake_marker;
            board.check_result(got);
        end
    end

    initial
    begin
        int directed_count;
        board = new();
        rst_n = 1'b0;
        chunk.valid = 1'b0;
        chunk.data_byte = '0;
        chunk.chunk_start = 1'b0;
        chunk.chunk_end = 1'b0;
        queue_directed();
        directed_count = chunk_bytes.size();
        while (chunk_bytes.size() < directed_count + 560)
        begin
            if ($urandom_range(4, 0) == 0)
                queue_noise();
            else
                queue_message(1'b0);
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        send_bytes();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (board.fails == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
